// File: design/rmst_pkg.sv
// ----------------------------------------------------------------------------
// rmst_pkg
// Shared constants, register indexes and controller/datapath interface types
// for the rectilinear spanning tree block.
// ----------------------------------------------------------------------------
package rmst_pkg;

  localparam int MAX_PINS   = 16;
  localparam int COORD_BITS = 16;
  localparam int CFG_W      = 8;
  localparam int IDX_W      = $clog2(MAX_PINS);
  localparam int CNT_W      = $clog2(MAX_PINS + 1);
  localparam int PIN_W      = 2 * COORD_BITS;
  localparam int PROD_W     = COORD_BITS + CFG_W;
  localparam int COST_W     = 25;
  localparam int TOTAL_W    = 29;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_VIA   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HORIZ = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VERT  = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic load;         // store an accepted pin
    logic scan_init;    // restart pair counters, drop best candidate
    logic issue;        // issue one pin pair into the cost pipe
    logic rel_init;     // restart relabel sweep
    logic rel_step;     // issue one relabel read
    logic emit;         // load the best edge into the output register
    logic emit_single;  // load the single-pin result
    logic clear;        // close the net
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic count_zero;
    logic scan_last;
    logic busy;
    logic rel_done;
    logic last_pick;
    logic out_free;
  } status_t;

endpackage

// File: design/rmst_ram.sv
// ----------------------------------------------------------------------------
// rmst_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module rmst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// File: design/rmst_datapath.sv
// ----------------------------------------------------------------------------
// rmst_datapath
// Pin and label stores, pair counters, three-stage edge cost pipe with
// running minimum, relabel sweep, totals and the output register.
// ----------------------------------------------------------------------------
module rmst_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [rmst_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [rmst_pkg::CFG_W-1:0]            cfg_data,
  input  logic [15:0]                           pin_x,
  input  logic [15:0]                           pin_y,
  input  rmst_pkg::cmd_t                        cmd,
  output rmst_pkg::status_t                     status,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [3:0]                            edge_from,
  output logic [3:0]                            edge_to,
  output logic [rmst_pkg::COST_W-1:0]           edge_cost,
  output logic [rmst_pkg::TOTAL_W-1:0]          total_cost,
  output logic                                  edge_valid,
  output logic                                  last_edge
);
  import rmst_pkg::*;

  logic [CFG_W-1:0] via_weight, horiz_cost, vert_cost;

  always_ff @(posedge clk) begin
    if (rst) begin
      via_weight <= CFG_W'(1);
      horiz_cost <= CFG_W'(1);
      vert_cost  <= CFG_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_VIA:   via_weight <= cfg_data;
        REG_HORIZ: horiz_cost <= cfg_data;
        REG_VERT:  vert_cost  <= cfg_data;
        default: ;
      endcase
    end
  end

  // pin count
  logic [CNT_W-1:0] count;
  logic             store_ok;
  assign store_ok = count < CNT_W'(MAX_PINS);

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      count <= '0;
    end else if (cmd.load && store_ok) begin
      count <= count + CNT_W'(1);
    end
  end

  // pair counters (i < j < count), lexicographic order
  logic [CNT_W-1:0] pi, pj;
  logic             pj_end;
  assign pj_end = (pj + CNT_W'(1)) == count;

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      pi <= '0;
      pj <= CNT_W'(1);
    end else if (cmd.issue) begin
      if (pj_end) begin
        pi <= pi + CNT_W'(1);
        pj <= pi + CNT_W'(2);
      end else begin
        pj <= pj + CNT_W'(1);
      end
    end
  end

  // relabel sweep counter
  logic [CNT_W-1:0] k;
  logic             k_go;
  logic             rel_v;
  logic [IDX_W-1:0] rk;
  assign k_go = cmd.rel_step && (k < count);

  always_ff @(posedge clk) begin
    if (cmd.rel_init) begin
      k <= '0;
    end else if (k_go) begin
      k <= k + CNT_W'(1);
    end
    rk <= k[IDX_W-1:0];
    if (rst) begin
      rel_v <= 1'b0;
    end else begin
      rel_v <= k_go;
    end
  end

  // stores
  logic [PIN_W-1:0] pin_a, pin_b;
  logic [IDX_W-1:0] lab_a, lab_b;
  logic [IDX_W-1:0] best_la, best_lb;
  logic             lab_we;

  assign lab_we = (cmd.load && store_ok) || (rel_v && (lab_a == best_lb));

  rmst_ram #(.WIDTH(PIN_W), .DEPTH(MAX_PINS)) u_pin_ram (
    .clk     (clk),
    .we      (cmd.load && store_ok),
    .waddr   (count[IDX_W-1:0]),
    .wdata   ({pin_y[COORD_BITS-1:0], pin_x[COORD_BITS-1:0]}),
    .raddr_a (pi[IDX_W-1:0]),
    .raddr_b (pj[IDX_W-1:0]),
    .rdata_a (pin_a),
    .rdata_b (pin_b)
  );

  rmst_ram #(.WIDTH(IDX_W), .DEPTH(MAX_PINS)) u_label_ram (
    .clk     (clk),
    .we      (lab_we),
    .waddr   (rel_v ? rk : count[IDX_W-1:0]),
    .wdata   (rel_v ? best_la : count[IDX_W-1:0]),
    .raddr_a (cmd.rel_step ? k[IDX_W-1:0] : pi[IDX_W-1:0]),
    .raddr_b (pj[IDX_W-1:0]),
    .rdata_a (lab_a),
    .rdata_b (lab_b)
  );

  // read stage
  logic             rv;
  logic [IDX_W-1:0] ri, rj;

  always_ff @(posedge clk) begin
    if (rst) begin
      rv <= 1'b0;
    end else begin
      rv <= cmd.issue;
    end
    ri <= pi[IDX_W-1:0];
    rj <= pj[IDX_W-1:0];
  end

  // stage 1: distances
  logic [COORD_BITS-1:0] xa, xb, ya, yb, dx, dy;
  assign xa = pin_a[COORD_BITS-1:0];
  assign xb = pin_b[COORD_BITS-1:0];
  assign ya = pin_a[PIN_W-1:COORD_BITS];
  assign yb = pin_b[PIN_W-1:COORD_BITS];
  assign dx = (xa > xb) ? xa - xb : xb - xa;
  assign dy = (ya > yb) ? ya - yb : yb - ya;

  logic                  s1v, s1_diff;
  logic [COORD_BITS-1:0] s1_dx, s1_dy;
  logic [IDX_W-1:0]      s1_i, s1_j, s1_la, s1_lb;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1v <= 1'b0;
    end else begin
      s1v <= rv;
    end
    s1_dx   <= dx;
    s1_dy   <= dy;
    s1_diff <= lab_a != lab_b;
    s1_i    <= ri;
    s1_j    <= rj;
    s1_la   <= lab_a;
    s1_lb   <= lab_b;
  end

  // stage 2: weights
  logic              s2v, s2_diff, s2_dynz;
  logic [PROD_W-1:0] s2_px, s2_py;
  logic [IDX_W-1:0]  s2_i, s2_j, s2_la, s2_lb;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2v <= 1'b0;
    end else begin
      s2v <= s1v;
    end
    s2_px   <= PROD_W'(s1_dx) * PROD_W'(horiz_cost);
    s2_py   <= PROD_W'(s1_dy) * PROD_W'(vert_cost);
    s2_dynz <= s1_dy != '0;
    s2_diff <= s1_diff;
    s2_i    <= s1_i;
    s2_j    <= s1_j;
    s2_la   <= s1_la;
    s2_lb   <= s1_lb;
  end

  // stage 3: sum and running minimum over crossing edges
  logic [COST_W-1:0] cand, best_cost;
  logic              best_found;
  logic [IDX_W-1:0]  best_i, best_j;

  assign cand = COST_W'(s2_px) + COST_W'(s2_py)
              + (s2_dynz ? COST_W'({via_weight, 1'b0}) : COST_W'(0));

  always_ff @(posedge clk) begin
    if (rst || cmd.scan_init) begin
      best_found <= 1'b0;
    end else if (s2v && s2_diff && (!best_found || cand < best_cost)) begin
      best_found <= 1'b1;
    end
    if (s2v && s2_diff && (!best_found || cand < best_cost)) begin
      best_cost <= cand;
      best_i    <= s2_i;
      best_j    <= s2_j;
      best_la   <= s2_la;
      best_lb   <= s2_lb;
    end
  end

  // picks and total
  logic [CNT_W-1:0]   picks;
  logic [TOTAL_W-1:0] total, total_new;
  logic               last_pick;
  assign last_pick = (picks + CNT_W'(2)) == count;
  assign total_new = total + TOTAL_W'(best_cost);

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      picks <= '0;
      total <= '0;
    end else if (cmd.emit) begin
      picks <= picks + CNT_W'(1);
      total <= total_new;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit || cmd.emit_single) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (cmd.emit) begin
      edge_from  <= 4'(best_i);
      edge_to    <= 4'(best_j);
      edge_cost  <= best_cost;
      total_cost <= last_pick ? total_new : '0;
      edge_valid <= 1'b1;
      last_edge  <= last_pick;
    end else if (cmd.emit_single) begin
      edge_from  <= '0;
      edge_to    <= '0;
      edge_cost  <= '0;
      total_cost <= '0;
      edge_valid <= 1'b0;
      last_edge  <= 1'b1;
    end
  end

  assign status.count_zero = count == '0;
  assign status.scan_last  = ((pi + CNT_W'(2)) == count) && pj_end;
  assign status.busy       = rv || s1v || s2v;
  assign status.rel_done   = (k == count) && !rel_v;
  assign status.last_pick  = last_pick;
  assign status.out_free   = !out_valid || !out_stall;

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit || cmd.emit_single) |-> (!out_valid || !out_stall))
    else $error("result loaded over an untaken beat");
  a_emit_found: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> best_found)
    else $error("edge emitted with no crossing candidate");
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_PINS))
    else $error("pin count overflow");
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(cmd.issue && (rel_v || cmd.rel_step)))
    else $error("scan and relabel overlap");

endmodule

// File: design/rmst_ctrl.sv
// ----------------------------------------------------------------------------
// rmst_ctrl
// Sequencer: load pins, scan all pairs for the cheapest crossing edge,
// emit it, merge components, repeat until the tree is complete.
// ----------------------------------------------------------------------------
module rmst_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              last_pin,
  input  rmst_pkg::status_t status,
  output rmst_pkg::cmd_t    cmd
);
  import rmst_pkg::*;

  typedef enum logic [2:0] {
    S_LOAD, S_SCAN, S_DRAIN, S_EMIT, S_RELABEL, S_SINGLE
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = state != S_LOAD;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_LOAD: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (last_pin) begin
            if (status.count_zero) begin
              state_next = S_SINGLE;
            end else begin
              cmd.scan_init = 1'b1;
              state_next    = S_SCAN;
            end
          end
        end
      end
      S_SCAN: begin
        cmd.issue = 1'b1;
        if (status.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!status.busy) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.last_pick) begin
            cmd.clear  = 1'b1;
            state_next = S_LOAD;
          end else begin
            cmd.rel_init = 1'b1;
            state_next   = S_RELABEL;
          end
        end
      end
      S_RELABEL: begin
        cmd.rel_step = 1'b1;
        if (status.rel_done) begin
          cmd.rel_step  = 1'b0;
          cmd.scan_init = 1'b1;
          state_next    = S_SCAN;
        end
      end
      S_SINGLE: begin
        if (status.out_free) begin
          cmd.emit_single = 1'b1;
          cmd.clear       = 1'b1;
          state_next      = S_LOAD;
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

endmodule

// File: design/rectilinear_spanning_tree.sv
// ----------------------------------------------------------------------------
// rectilinear_spanning_tree
// Minimum rectilinear spanning tree of one net, edges given in cost order.
// ----------------------------------------------------------------------------
// Pins are taken one beat per cycle until a beat with last_pin set; pins past
// 16 are dropped but their mark still closes the net. For a net of n pins the
// block then runs n-1 rounds. Each round scans all n(n-1)/2 pin pairs through
// a 3-stage cost pipe fed by the dual-port pin and label RAMs, one pair per
// cycle, and keeps the cheapest pair whose pins lie in different components
// (lowest pair index wins a tie). Once the pipe has drained, that edge is
// emitted, waiting while the output is stalled, and then a sweep over the
// pins merges the two component labels; the last round skips the sweep.
// Pins are not accepted while a net is being worked. A single-pin net yields
// one beat with edge_valid low.
// total_cost is nonzero only on the beat with last_edge set.
module rectilinear_spanning_tree (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [rmst_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rmst_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [15:0]                    pin_x,
  input  logic [15:0]                    pin_y,
  input  logic                           last_pin,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [3:0]                     edge_from,
  output logic [3:0]                     edge_to,
  output logic [rmst_pkg::COST_W-1:0]    edge_cost,
  output logic [rmst_pkg::TOTAL_W-1:0]   total_cost,
  output logic                           edge_valid,
  output logic                           last_edge
);
  import rmst_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencer
  rmst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .last_pin (last_pin),
    .status   (status),
    .cmd      (cmd)
  );

  // stores, cost pipe, merge and output register
  rmst_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pin_x      (pin_x),
    .pin_y      (pin_y),
    .cmd        (cmd),
    .status     (status),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .edge_from  (edge_from),
    .edge_to    (edge_to),
    .edge_cost  (edge_cost),
    .total_cost (total_cost),
    .edge_valid (edge_valid),
    .last_edge  (last_edge)
  );

endmodule
